// File: rtl/core/idcd_pkg.sv
// ----------------------------------------------------------------------------
// idcd_pkg: shared types and constants of the datagram CRC deframer
// CRC-32 constants, the per-byte CRC update, the decoded sample and the
// check result that the back end hands to the front end.
// ----------------------------------------------------------------------------
package idcd_pkg;

  localparam logic [31:0] CrcPoly     = 32'h04C1_1DB7;
  localparam logic [31:0] CrcInit     = 32'hFFFF_FFFF;
  localparam logic [7:0]  HeaderReset = 8'd147;

  // Six raw signed 24-bit counts of one datagram.
  typedef struct packed {
    logic signed [23:0] gyro_x;
    logic signed [23:0] gyro_y;
    logic signed [23:0] gyro_z;
    logic signed [23:0] accel_x;
    logic signed [23:0] accel_y;
    logic signed [23:0] accel_z;
  } imu_sample_t;

  // Completion of one window check.
  typedef struct packed {
    logic valid;
    logic match;
  } chk_done_t;

  // MSB-first CRC-32 update by one byte.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'd0};
    for (int k = 0; k < 8; k++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/core/imu_datagram_crc_deframer_top.sv
// ----------------------------------------------------------------------------
// imu_datagram_crc_deframer_top: CRC-checked IMU datagram deframer
// Serial bytes in, decoded gyro and accel counts out.
// ----------------------------------------------------------------------------
// Usage:
//   Input is a queue write port: a byte is taken when push is high and full
//   is low. Results come out of a queue read port: while empty is low the
//   oldest sample is on gyro_*_o / accel_*_o and pop takes it.
//   The header byte register is written through cfg_valid_i / cfg_data_i;
//   cfg_ready_o is always high. Write it only while the block is idle.
// Timing:
//   A byte that leaves the window short of full starts no check, and full
//   stays low. Once the window is full every byte starts a check: a sweep
//   of the window memory through its single read port, one byte a cycle;
//   full stays high until the check ends, on a match, on a CRC mismatch,
//   or as soon as the oldest byte is found not to be a header. A sample
//   lands in the cycle before full drops.
// Reset:
//   The window and the result queue are empty, the header register holds
//   0x93. The window memory itself is not cleared.
// Stall:
//   A two-entry result queue absorbs a slow receiver; when it is full the
//   check engine holds its sample, and input stays blocked until it lands.
// ----------------------------------------------------------------------------
module imu_datagram_crc_deframer_top #(
  parameter int DATAGRAM_BYTES = 38
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [23:0] gyro_x_o,
  output logic signed [23:0] gyro_y_o,
  output logic signed [23:0] gyro_z_o,
  output logic signed [23:0] accel_x_o,
  output logic signed [23:0] accel_y_o,
  output logic signed [23:0] accel_z_o
);

  localparam int IdxW = $clog2(DATAGRAM_BYTES);

  logic [7:0]            header_q;
  logic                  wr_en;
  logic [IdxW-1:0]       wr_addr;
  logic [7:0]            wr_data;
  logic                  job_valid, job_ready;
  logic [IdxW-1:0]       job_base;
  idcd_pkg::chk_done_t   chk_done;
  logic                  smp_push, smp_full;
  idcd_pkg::imu_sample_t smp, res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= idcd_pkg::HeaderReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      header_q <= cfg_data_i;
    end
  end

  idcd_front #(.DATAGRAM_BYTES(DATAGRAM_BYTES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .data_byte_i (data_byte_i),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_base_o  (job_base),
    .done_i      (chk_done)
  );

  idcd_back #(.DATAGRAM_BYTES(DATAGRAM_BYTES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .header_i    (header_q),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_base_i  (job_base),
    .done_o      (chk_done),
    .smp_push_o  (smp_push),
    .smp_full_i  (smp_full),
    .smp_o       (smp)
  );

  idcd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (smp_push),
    .full_o  (smp_full),
    .data_i  (smp),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res)
  );

  assign gyro_x_o  = res.gyro_x;
  assign gyro_y_o  = res.gyro_y;
  assign gyro_z_o  = res.gyro_z;
  assign accel_x_o = res.accel_x;
  assign accel_y_o = res.accel_y;
  assign accel_z_o = res.accel_z;

endmodule

// File: rtl/core/idcd_front.sv
// ----------------------------------------------------------------------------
// idcd_front: byte intake of the deframer
// Writes each accepted byte into the circular window, tracks the fill level
// and posts a check job once the window is full; holds off input until the
// back end reports the result of that check.
// ----------------------------------------------------------------------------
module idcd_front #(
  parameter int DATAGRAM_BYTES = 38
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  output logic                              full_o,
  input  logic [7:0]                        data_byte_i,
  output logic                              wr_en_o,
  output logic [$clog2(DATAGRAM_BYTES)-1:0] wr_addr_o,
  output logic [7:0]                        wr_data_o,
  output logic                              job_valid_o,
  input  logic                              job_ready_i,
  output logic [$clog2(DATAGRAM_BYTES)-1:0] job_base_o,
  input  idcd_pkg::chk_done_t               done_i
);

  localparam int IdxW = $clog2(DATAGRAM_BYTES);
  localparam int CntW = $clog2(DATAGRAM_BYTES + 1);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(DATAGRAM_BYTES - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(DATAGRAM_BYTES);
  localparam logic [CntW-1:0] AlmostCnt = CntW'(DATAGRAM_BYTES - 1);

  logic [CntW-1:0] fill_q, fill_d;
  logic [IdxW-1:0] wptr_q, wptr_d;
  logic [IdxW-1:0] base_q, base_d;
  logic            busy_q, busy_d;
  logic            job_valid_q, job_valid_d;
  logic            accept;

  assign accept      = push_i && !busy_q;
  assign full_o      = busy_q;
  assign wr_en_o     = accept;
  assign wr_addr_o   = wptr_q;
  assign wr_data_o   = data_byte_i;
  assign job_valid_o = job_valid_q;
  assign job_base_o  = base_q;

  always_comb begin
    fill_d      = fill_q;
    wptr_d      = wptr_q;
    base_d      = base_q;
    busy_d      = busy_q;
    job_valid_d = job_valid_q;
    if (accept) begin
      wptr_d = (wptr_q == LastIdx) ? '0 : wptr_q + 1'b1;
      if (fill_q != FullCnt) begin
        fill_d = fill_q + 1'b1;
      end
      // window full after this byte: the oldest byte sits at the next write slot
      if (fill_q == AlmostCnt || fill_q == FullCnt) begin
        busy_d      = 1'b1;
        job_valid_d = 1'b1;
        base_d      = wptr_d;
      end
    end
    if (job_valid_q && job_ready_i) begin
      job_valid_d = 1'b0;
    end
    if (done_i.valid) begin
      busy_d = 1'b0;
      if (done_i.match) begin
        fill_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      wptr_q      <= '0;
      busy_q      <= 1'b0;
      job_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      wptr_q      <= wptr_d;
      busy_q      <= busy_d;
      job_valid_q <= job_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
  end

endmodule

// File: rtl/core/idcd_back.sv
// ----------------------------------------------------------------------------
// idcd_back: window check engine
// Holds the byte window memory. For each job it sweeps the window oldest
// first, one byte a cycle, checks the header, runs the CRC, collects the
// trailing CRC and the field bytes, then emits a sample on a match.
// ----------------------------------------------------------------------------
module idcd_back #(
  parameter int DATAGRAM_BYTES = 38
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [7:0]                        header_i,
  input  logic                              wr_en_i,
  input  logic [$clog2(DATAGRAM_BYTES)-1:0] wr_addr_i,
  input  logic [7:0]                        wr_data_i,
  input  logic                              job_valid_i,
  output logic                              job_ready_o,
  input  logic [$clog2(DATAGRAM_BYTES)-1:0] job_base_i,
  output idcd_pkg::chk_done_t               done_o,
  output logic                              smp_push_o,
  input  logic                              smp_full_i,
  output idcd_pkg::imu_sample_t             smp_o
);

  localparam int IdxW = $clog2(DATAGRAM_BYTES);
  localparam int CntW = $clog2(DATAGRAM_BYTES + 1);
  localparam int FldBytes = 20;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DATAGRAM_BYTES - 1);
  localparam logic [IdxW-1:0] BodyIdx = IdxW'(DATAGRAM_BYTES - 4);
  localparam logic [CntW-1:0] FullCnt = CntW'(DATAGRAM_BYTES);
  localparam logic [1:0]      PadCnt  = 2'((4 - (DATAGRAM_BYTES % 4)) % 4);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StPad  = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [7:0] win_mem [DATAGRAM_BYTES];

  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  iss_q, iss_d;
  logic [IdxW-1:0]  addr_q, addr_d;
  logic             dv_q;
  logic [IdxW-1:0]  dk_q;
  logic [7:0]       rdata_q;
  logic [1:0]       pad_q, pad_d;
  logic [31:0]      crc_q;
  logic [31:0]      rx_q;
  logic [7:0]       fld_q [FldBytes];
  idcd_pkg::chk_done_t done_q, done_d;

  logic take, rd_en, proc, hdr_bad, pad_feed;

  assign job_ready_o = (state_q == StIdle);
  assign take        = job_valid_i && (state_q == StIdle);
  assign rd_en       = (state_q == StRead) && (iss_q != FullCnt);
  assign proc        = (state_q == StRead) && dv_q;
  assign hdr_bad     = proc && (dk_q == '0) && (rdata_q != header_i);
  assign pad_feed    = (state_q == StPad) && (pad_q != 2'd0);
  assign done_o      = done_q;
  assign smp_push_o  = (state_q == StEmit) && !smp_full_i;

  always_comb begin
    smp_o.gyro_x  = $signed({fld_q[1],  fld_q[2],  fld_q[3]});
    smp_o.gyro_y  = $signed({fld_q[4],  fld_q[5],  fld_q[6]});
    smp_o.gyro_z  = $signed({fld_q[7],  fld_q[8],  fld_q[9]});
    smp_o.accel_x = $signed({fld_q[11], fld_q[12], fld_q[13]});
    smp_o.accel_y = $signed({fld_q[14], fld_q[15], fld_q[16]});
    smp_o.accel_z = $signed({fld_q[17], fld_q[18], fld_q[19]});
  end

  always_comb begin
    state_d = state_q;
    iss_d   = iss_q;
    addr_d  = addr_q;
    pad_d   = pad_q;
    done_d  = '0;
    unique case (state_q)
      StIdle: begin
        if (take) begin
          state_d = StRead;
          iss_d   = '0;
          addr_d  = job_base_i;
        end
      end
      StRead: begin
        if (rd_en) begin
          iss_d  = iss_q + 1'b1;
          addr_d = (addr_q == LastIdx) ? '0 : addr_q + 1'b1;
        end
        if (hdr_bad) begin
          // drop the check at once; reads still in flight are ignored
          state_d = StIdle;
          done_d  = '{valid: 1'b1, match: 1'b0};
        end else if (proc && dk_q == LastIdx) begin
          state_d = StPad;
          pad_d   = PadCnt;
        end
      end
      StPad: begin
        if (pad_q != 2'd0) begin
          pad_d = pad_q - 1'b1;
        end else if (rx_q == crc_q) begin
          state_d = StEmit;
        end else begin
          state_d = StIdle;
          done_d  = '{valid: 1'b1, match: 1'b0};
        end
      end
      StEmit: begin
        if (!smp_full_i) begin
          state_d = StIdle;
          done_d  = '{valid: 1'b1, match: 1'b1};
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      iss_q   <= '0;
      dv_q    <= 1'b0;
      done_q  <= '0;
    end else begin
      state_q <= state_d;
      iss_q   <= iss_d;
      dv_q    <= rd_en;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      win_mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en) begin
      rdata_q <= win_mem[addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    pad_q  <= pad_d;
    dk_q   <= iss_q[IdxW-1:0];
    if (take) begin
      crc_q <= idcd_pkg::CrcInit;
    end else if (proc && dk_q < BodyIdx) begin
      crc_q <= idcd_pkg::crc32_byte(crc_q, rdata_q);
    end else if (pad_feed) begin
      crc_q <= idcd_pkg::crc32_byte(crc_q, 8'd0);
    end
    if (proc && dk_q >= BodyIdx) begin
      rx_q <= {rx_q[23:0], rdata_q};
    end
    // field positions past the end of a short window stay zero
    for (int i = 0; i < FldBytes; i++) begin
      if (take) begin
        fld_q[i] <= 8'd0;
      end else if (proc && int'(dk_q) == i) begin
        fld_q[i] <= rdata_q;
      end
    end
  end

endmodule

// File: rtl/core/idcd_fifo.sv
// ----------------------------------------------------------------------------
// idcd_fifo: result queue
// Two-entry queue of decoded samples between the check engine and the
// result port, so a stalled receiver holds up the engine only once both entries are taken.
// ----------------------------------------------------------------------------
module idcd_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  idcd_pkg::imu_sample_t data_i,
  input  logic                  pop_i,
  output logic                  empty_o,
  output idcd_pkg::imu_sample_t data_o
);

  localparam logic [1:0] Depth = 2'd2;

  idcd_pkg::imu_sample_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == Depth);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wp_q <= ~wp_q;
      end
      if (do_pop) begin
        rp_q <= ~rp_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

// File: bench/tb_imu_datagram_crc_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imu_datagram_crc_deframer_top: self-checking bench of the IMU deframer
// Feeds whole datagrams, corrupted datagrams, wrong headers and line noise
// byte by byte, mirrors the sliding window and CRC-32 check in a local
// predictor, and compares every popped sample field by field. The header
// register is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_imu_datagram_crc_deframer_top;

  localparam int          FrameLen     = 38;
  localparam int          BodyLen      = FrameLen - 4;
  localparam int          PadLen       = (4 - BodyLen % 4) % 4;
  localparam logic [31:0] CrcGen       = 32'h04C1_1DB7;
  localparam logic [31:0] CrcSeed      = 32'hFFFF_FFFF;
  localparam int          ItemTarget   = 1600;
  localparam int          SettleCycles = 100;
  localparam int          StallLimit   = 4000;
  localparam int          MaxReports   = 10;
  localparam int          CfgEvery     = 250;
  localparam int          FieldOff [6] = '{1, 4, 7, 11, 14, 17};
  localparam string       FieldName [6] = '{"gyro_x", "gyro_y", "gyro_z",
                                            "accel_x", "accel_y", "accel_z"};

  typedef logic [7:0] frame_t [FrameLen];

  typedef enum logic [1:0] {
    ROW_GOOD,
    ROW_BAD_CRC,
    ROW_NOISE,
    ROW_CFG
  } row_kind_e;

  // typed = expectation comes from the row itself, not from the predictor
  typedef struct {
    row_kind_e             kind;
    logic [7:0]            hdr;
    idcd_pkg::imu_sample_t smp;
    logic [7:0]            fill;
    int                    len;
    bit                    typed;
    bit                    hit;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic [7:0]         data_byte_i;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [7:0]         cfg_data_i;
  logic               empty;
  logic               pop;
  logic signed [23:0] gyro_x_o;
  logic signed [23:0] gyro_y_o;
  logic signed [23:0] gyro_z_o;
  logic signed [23:0] accel_x_o;
  logic signed [23:0] accel_y_o;
  logic signed [23:0] accel_z_o;

  // predictor state
  frame_t                win;
  int                    win_fill;
  logic [7:0]            hdr_reg;
  idcd_pkg::imu_sample_t pending_samples [$];

  stim_row_t   dir_rows [$];
  int          items_sent;
  int          mismatches;
  int          quiet_cycles;
  int          send_idle_pct;
  int          recv_idle_pct;

  imu_datagram_crc_deframer_top #(
    .DATAGRAM_BYTES(FrameLen)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .data_byte_i(data_byte_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .empty      (empty),
    .pop        (pop),
    .gyro_x_o   (gyro_x_o),
    .gyro_y_o   (gyro_y_o),
    .gyro_z_o   (gyro_z_o),
    .accel_x_o  (accel_x_o),
    .accel_y_o  (accel_y_o),
    .accel_z_o  (accel_z_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [31:0] crc_shift_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h0};
    repeat (8) c = c[31] ? ((c << 1) ^ CrcGen) : (c << 1);
    return c;
  endfunction

  // CRC over the body plus zero padding up to a word boundary
  function automatic logic [31:0] frame_crc(input frame_t fr);
    logic [31:0] c;
    c = CrcSeed;
    for (int i = 0; i < BodyLen + PadLen; i++) begin
      c = crc_shift_byte(c, (i < BodyLen) ? fr[i] : 8'h00);
    end
    return c;
  endfunction

  // Advance the mirrored window by one byte; return 1 when a datagram checks out.
  function automatic bit deframe_byte(input logic [7:0] b,
                                      output idcd_pkg::imu_sample_t smp);
    logic [143:0] flat;
    smp = '0;
    flat = '0;
    if (win_fill < FrameLen) begin
      win[win_fill] = b;
      win_fill++;
    end else begin
      for (int i = 0; i < FrameLen - 1; i++) win[i] = win[i + 1];
      win[FrameLen - 1] = b;
    end
    if (win_fill != FrameLen || win[0] != hdr_reg) return 1'b0;
    if ({win[BodyLen], win[BodyLen + 1], win[BodyLen + 2], win[BodyLen + 3]} != frame_crc(win))
      return 1'b0;
    for (int j = 0; j < 6; j++) begin
      flat[143 - 24 * j -: 24] = {win[FieldOff[j]], win[FieldOff[j] + 1], win[FieldOff[j] + 2]};
    end
    smp = flat;
    win_fill = 0;
    return 1'b1;
  endfunction

  function automatic frame_t make_frame(input logic [7:0] hdr, input idcd_pkg::imu_sample_t smp,
                                        input logic [7:0] fill, input bit rand_fill);
    frame_t       fr;
    logic [143:0] flat;
    logic [31:0]  c;
    flat = smp;
    for (int i = 0; i < BodyLen; i++) fr[i] = rand_fill ? 8'($urandom) : fill;
    fr[0] = hdr;
    for (int j = 0; j < 6; j++) begin
      {fr[FieldOff[j]], fr[FieldOff[j] + 1], fr[FieldOff[j] + 2]} = flat[143 - 24 * j -: 24];
    end
    c = frame_crc(fr);
    {fr[BodyLen], fr[BodyLen + 1], fr[BodyLen + 2], fr[BodyLen + 3]} = c;
    return fr;
  endfunction

  // append one row to the directed table
  function automatic void add_row(input stim_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // favor the sign boundaries now and then
  function automatic logic [23:0] rand_count();
    case ($urandom_range(0, 9))
      0:       return 24'h800000;
      1:       return 24'h7FFFFF;
      2:       return ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic note_mismatch(input string what, input logic [23:0] want, input logic [23:0] got);
    if (mismatches < MaxReports) begin
      $display("%0t ns: %s mismatch: expected %h, got %h", $time, what, want, got);
    end
    mismatches++;
  endtask

  task automatic push_byte(input logic [7:0] b, input bit typed_row);
    idcd_pkg::imu_sample_t smp;
    bit                    hit;
    if (items_sent < 550) begin
      send_idle_pct = 35;
      recv_idle_pct = 71;
    end else if (items_sent < 1100) begin
      send_idle_pct = 71;
      recv_idle_pct = 35;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (full);
    items_sent++;
    hit = deframe_byte(b, smp);
    if (hit && !typed_row) begin
      pending_samples.insert(pending_samples.size(), smp);
    end
  endtask

  // Drain all results, let a check in flight finish, then write the header.
  task automatic write_header(input logic [7:0] v);
    push <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    hdr_reg = v;
  endtask

  task automatic run_row(input stim_row_t r);
    frame_t fr;
    case (r.kind)
      ROW_GOOD, ROW_BAD_CRC: begin
        fr = make_frame(r.hdr, r.smp, r.fill, !r.typed);
        // flip a single bit so the CRC cannot match
        if (r.kind == ROW_BAD_CRC) fr[r.len] ^= 8'(1 << (r.len % 8));
        for (int i = 0; i < FrameLen; i++) push_byte(fr[i], r.typed);
      end
      ROW_NOISE: begin
        for (int i = 0; i < r.len; i++) begin
          push_byte(($urandom_range(0, 7) == 0) ? hdr_reg : 8'($urandom), r.typed);
        end
      end
      ROW_CFG: write_header(r.hdr);
      default: ;
    endcase
    if (r.typed && r.hit) begin
      pending_samples.insert(pending_samples.size(), r.smp);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    idcd_pkg::imu_sample_t want;
    logic [143:0]          got_flat;
    logic [143:0]          want_flat;
    if (rst_ni && pop && !empty) begin
      got_flat = {gyro_x_o, gyro_y_o, gyro_z_o, accel_x_o, accel_y_o, accel_z_o};
      if (pending_samples.size() == 0) begin
        note_mismatch("unexpected sample, gyro_x", 24'h0, got_flat[143 -: 24]);
      end else begin
        want      = pending_samples.pop_front();
        want_flat = want;
        for (int j = 0; j < 6; j++) begin
          if (got_flat[143 - 24 * j -: 24] !== want_flat[143 - 24 * j -: 24]) begin
            note_mismatch(FieldName[j], want_flat[143 - 24 * j -: 24],
                          got_flat[143 - 24 * j -: 24]);
          end
        end
      end
    end
    pop <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog: end the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("tb_imu_datagram_crc_deframer_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    stim_row_t row;
    int        pick;
    int        last_cfg_items;
    int        cfg_n;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    push          = 1'b0;
    data_byte_i   = 8'h00;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = 8'h00;
    pop           = 1'b0;
    win_fill      = 0;
    hdr_reg       = idcd_pkg::HeaderReset;
    items_sent    = 0;
    mismatches    = 0;
    quiet_cycles  = 0;
    send_idle_pct = 35;
    recv_idle_pct = 71;
    last_cfg_items = 0;
    cfg_n         = 0;

    // clean-window datagrams at the field extremes, then a bad CRC: expected by eye
    add_row('{ROW_GOOD, idcd_pkg::HeaderReset, {6{24'h000000}}, 8'h00, 0, 1'b1, 1'b1});
    add_row('{ROW_GOOD, idcd_pkg::HeaderReset, {6{24'h7FFFFF}}, 8'hFF, 0, 1'b1, 1'b1});
    add_row('{ROW_GOOD, idcd_pkg::HeaderReset, {6{24'h800000}}, 8'h80, 0, 1'b1, 1'b1});
    add_row('{ROW_GOOD, idcd_pkg::HeaderReset, {6{24'hFFFFFF}}, 8'h7F, 0, 1'b1, 1'b1});
    add_row('{ROW_BAD_CRC, idcd_pkg::HeaderReset, {6{24'h5A5A5A}}, 8'h5A, 20, 1'b1, 1'b0});
    // window now full and sliding: the predictor takes over
    add_row('{ROW_GOOD, idcd_pkg::HeaderReset,
              {24'h123456, 24'hFEDCBA, 24'h000001, 24'h800001, 24'h7FFFFE, 24'hABCDEF},
              8'h00, 0, 1'b0, 1'b0});
    add_row('{ROW_NOISE, 8'h00, {6{24'h000000}}, 8'h00, 20, 1'b0, 1'b0});
    add_row('{ROW_GOOD, 8'h92, {6{24'h0F0F0F}}, 8'h00, 0, 1'b0, 1'b0});
    add_row('{ROW_GOOD, idcd_pkg::HeaderReset,
              {24'hF00000, 24'h0000FF, 24'h00FF00, 24'hC3C3C3, 24'h3C3C3C, 24'h010203},
              8'h00, 0, 1'b0, 1'b0});
    add_row('{ROW_CFG, 8'h00, {6{24'h000000}}, 8'h00, 0, 1'b0, 1'b0});
    add_row('{ROW_GOOD, 8'h00, {6{24'h800000}}, 8'h00, 0, 1'b0, 1'b0});
    add_row('{ROW_BAD_CRC, 8'h00, {6{24'h7FFFFF}}, 8'h00, 37, 1'b0, 1'b0});
    add_row('{ROW_CFG, 8'hFF, {6{24'h000000}}, 8'h00, 0, 1'b0, 1'b0});
    add_row('{ROW_GOOD, 8'hFF, {6{24'hFFFFFF}}, 8'h00, 0, 1'b0, 1'b0});
    add_row('{ROW_NOISE, 8'h00, {6{24'h000000}}, 8'h00, 45, 1'b0, 1'b0});
    add_row('{ROW_GOOD, 8'hFF,
              {24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'h555555, 24'hAAAAAA},
              8'h00, 0, 1'b0, 1'b0});
    add_row('{ROW_CFG, idcd_pkg::HeaderReset, {6{24'h000000}}, 8'h00, 0, 1'b0, 1'b0});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) run_row(dir_rows[i]);
    last_cfg_items = items_sent;

    // mostly well-formed datagrams with random content, the rest broken or noise
    while (items_sent < ItemTarget) begin
      if (items_sent - last_cfg_items >= CfgEvery) begin
        write_header((cfg_n % 3 == 0) ? idcd_pkg::HeaderReset : 8'($urandom_range(0, 255)));
        last_cfg_items = items_sent;
        cfg_n++;
      end
      pick      = $urandom_range(0, 99);
      row.hdr   = hdr_reg;
      row.smp   = {rand_count(), rand_count(), rand_count(),
                   rand_count(), rand_count(), rand_count()};
      row.fill  = 8'h00;
      row.len   = 0;
      row.typed = 1'b0;
      row.hit   = 1'b0;
      if (pick < 65) begin
        row.kind = ROW_GOOD;
      end else if (pick < 80) begin
        row.kind = ROW_BAD_CRC;
        row.len  = $urandom_range(0, FrameLen - 1);
      end else if (pick < 90) begin
        row.kind = ROW_GOOD;
        row.hdr  = hdr_reg ^ 8'($urandom_range(1, 255));
      end else begin
        row.kind = ROW_NOISE;
        row.len  = $urandom_range(1, 50);
      end
      run_row(row);
    end
    push <= 1'b0;

    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("tb_imu_datagram_crc_deframer_top passed");
    end else begin
      $display("tb_imu_datagram_crc_deframer_top failed");
    end
    $finish;
  end

endmodule

// File: imu_datagram_crc_deframer_top.f
rtl/core/idcd_pkg.sv
rtl/core/idcd_front.sv
rtl/core/idcd_back.sv
rtl/core/idcd_fifo.sv
rtl/core/imu_datagram_crc_deframer_top.sv
bench/tb_imu_datagram_crc_deframer_top.sv
